// ===== rtl/orl_pkg.sv =====
// Shared constants and types of the ordered record list.
`timescale 1ns / 1ps

package orl_pkg;

    // default sizing
    localparam int CAPACITY_DEF   = 128;
    localparam int NAME_BYTES_DEF = 32;

    // fixed field widths
    localparam int ID_W        = 32;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 8;
    localparam int COUNT_W     = 8;
    localparam int NAME_WORD_W = 64;
    localparam int NAME_WORDS  = 4;
    localparam int NAME_ALL_W  = NAME_WORD_W * NAME_WORDS;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_EDIT   = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_POS   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

endpackage

// ===== rtl/orl_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module orl_ram #(
    parameter int WIDTH = orl_pkg::ID_W,
    parameter int DEPTH = orl_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ordered_record_list_unit.sv =====
// Top level of the ordered record list: command sequencer around one record RAM.
`timescale 1ns / 1ps

// Ordered table of up to CAPACITY records (id, age, group, name) plus a count.
// Command channel: a word is taken at the clock edge where start is high and
// busy is low. busy stays high until the result has been produced.
// Result channel: o_valid is high for exactly one cycle with status, count and
// read fields; the receiver cannot stall, so the word must be taken then.
// Records live in one RAM, one record per address, registered read.
// Each command is a scan of the RAM: a read is issued every cycle and the
// data comes back in the next cycle, where it is copied, compared or captured.
//   insert : count - position + 1 copies upward, then the new record
//   delete : count - position copies downward
//   edit   : count reads, matching entries overwritten in place
//   read   : one read
// A command's run time grows with its reads: the single RAM read port allows one
// access a cycle. A command with no reads (rejected, append, delete of the last
// entry, edit of an empty table) passes through the scan state without reading
// the RAM. busy drops in the strobe cycle, so the next command may be taken there.
// Reset clears the count (empty table) and the sequencer; RAM contents are not
// cleared and are never read before written.
module ordered_record_list_unit #(
    parameter int CAPACITY   = orl_pkg::CAPACITY_DEF,
    parameter int NAME_BYTES = orl_pkg::NAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic [orl_pkg::POS_W-1:0]           i_position,
    input  logic signed [orl_pkg::ID_W-1:0]     i_match_id,
    input  logic signed [orl_pkg::ID_W-1:0]     i_new_id,
    input  logic [orl_pkg::BYTE_W-1:0]          i_new_age,
    input  logic [orl_pkg::BYTE_W-1:0]          i_new_group,
    input  logic [orl_pkg::NAME_WORD_W-1:0]     i_new_name_w0,
    input  logic [orl_pkg::NAME_WORD_W-1:0]     i_new_name_w1,
    input  logic [orl_pkg::NAME_WORD_W-1:0]     i_new_name_w2,
    input  logic [orl_pkg::NAME_WORD_W-1:0]     i_new_name_w3,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic [orl_pkg::COUNT_W-1:0]         o_count_now,
    output logic signed [orl_pkg::ID_W-1:0]     o_read_id,
    output logic [orl_pkg::BYTE_W-1:0]          o_read_age,
    output logic [orl_pkg::BYTE_W-1:0]          o_read_group,
    output logic [orl_pkg::NAME_WORD_W-1:0]     o_read_name_w0,
    output logic [orl_pkg::NAME_WORD_W-1:0]     o_read_name_w1,
    output logic [orl_pkg::NAME_WORD_W-1:0]     o_read_name_w2,
    output logic [orl_pkg::NAME_WORD_W-1:0]     o_read_name_w3
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int NAME_W = NAME_BYTES * orl_pkg::BYTE_W;
    localparam int REC_W  = orl_pkg::ID_W + 2 * orl_pkg::BYTE_W + NAME_W;
    // record layout: {id, age, group, name}
    localparam int GRP_LO = NAME_W;
    localparam int AGE_LO = NAME_W + orl_pkg::BYTE_W;
    localparam int ID_LO  = NAME_W + 2 * orl_pkg::BYTE_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    orl_pkg::t_action   r_action, n_action;
    logic [orl_pkg::POS_W-1:0] r_pos, n_pos;
    logic [orl_pkg::ID_W-1:0]  r_key, n_key;
    logic [REC_W-1:0]   r_new_rec, n_new_rec;
    orl_pkg::t_status   r_status, n_status;
    logic [CW-1:0]      r_left, n_left;     // reads still to issue
    logic [AW-1:0]      r_idx, n_idx;       // next read address
    logic               r_pend, n_pend;     // read data due this cycle
    logic [AW-1:0]      r_pend_addr, n_pend_addr;
    logic               r_found, n_found;
    logic [REC_W-1:0]   r_rd_rec, n_rd_rec;
    logic               r_valid, n_valid;
    orl_pkg::t_status   r_o_status, n_o_status;
    logic [CW-1:0]      r_o_count, n_o_count;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [REC_W-1:0]   ram_wdata;
    logic [REC_W-1:0]   ram_rdata;

    logic [orl_pkg::NAME_ALL_W-1:0] w_in_name;
    logic [orl_pkg::NAME_ALL_W-1:0] w_rd_name;
    logic [orl_pkg::POS_W:0]        w_pos9;
    logic [orl_pkg::POS_W:0]        w_cnt9;
    logic                           w_issue;

    orl_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign w_in_name = {i_new_name_w3, i_new_name_w2, i_new_name_w1, i_new_name_w0};
    assign w_pos9    = (orl_pkg::POS_W + 1)'(i_position);
    assign w_cnt9    = (orl_pkg::POS_W + 1)'(r_count);
    assign w_issue   = (r_left != '0);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_action    = r_action;
        n_pos       = r_pos;
        n_key       = r_key;
        n_new_rec   = r_new_rec;
        n_status    = r_status;
        n_left      = r_left;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_found     = r_found;
        n_rd_rec    = r_rd_rec;
        n_valid     = 1'b0;
        n_o_status  = r_o_status;
        n_o_count   = r_o_count;
        ram_we      = 1'b0;
        ram_waddr   = r_pend_addr;
        ram_wdata   = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state   = S_SCAN;
                    n_action  = orl_pkg::t_action'(i_action);
                    n_pos     = i_position;
                    n_key     = i_match_id;
                    n_new_rec = {i_new_id, i_new_age, i_new_group, w_in_name[NAME_W-1:0]};
                    n_status  = orl_pkg::STAT_OK;
                    n_found   = 1'b0;
                    n_rd_rec  = '0;
                    n_left    = '0;
                    n_idx     = '0;
                    unique case (orl_pkg::t_action'(i_action))
                        orl_pkg::ACT_INSERT: begin
                            if (i_position == '0 || w_pos9 > w_cnt9 + 1'b1) begin
                                n_status = orl_pkg::STAT_BAD_POS;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = orl_pkg::STAT_FULL;
                            end else begin
                                // move entries pos-1 .. count-1 up, top first
                                n_left = CW'(w_cnt9 - w_pos9 + 1'b1);
                                n_idx  = AW'(w_cnt9 - 1'b1);
                            end
                        end
                        orl_pkg::ACT_DELETE: begin
                            if (i_position == '0 || w_pos9 > w_cnt9) begin
                                n_status = orl_pkg::STAT_BAD_POS;
                            end else begin
                                // move entries pos .. count-1 down, bottom first
                                n_left = CW'(w_cnt9 - w_pos9);
                                n_idx  = AW'(w_pos9);
                            end
                        end
                        orl_pkg::ACT_EDIT: begin
                            n_left = r_count;
                        end
                        orl_pkg::ACT_READ: begin
                            if (i_position == '0 || w_pos9 > w_cnt9) begin
                                n_status = orl_pkg::STAT_BAD_POS;
                            end else begin
                                n_left = CW'(1);
                                n_idx  = AW'(w_pos9 - 1'b1);
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_issue) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx;
                    n_left      = r_left - 1'b1;
                    n_idx       = (r_action == orl_pkg::ACT_INSERT) ? r_idx - 1'b1
                                                                    : r_idx + 1'b1;
                end
                if (r_pend) begin
                    unique case (r_action)
                        orl_pkg::ACT_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pend_addr + 1'b1;
                        end
                        orl_pkg::ACT_DELETE: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pend_addr - 1'b1;
                        end
                        orl_pkg::ACT_EDIT: begin
                            if (ram_rdata[REC_W-1:ID_LO] == r_key) begin
                                ram_we    = 1'b1;
                                ram_wdata = r_new_rec;
                                n_found   = 1'b1;
                            end
                        end
                        orl_pkg::ACT_READ: begin
                            n_rd_rec = ram_rdata;
                        end
                    endcase
                end
                if (!w_issue && !r_pend) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                n_state    = S_IDLE;
                n_valid    = 1'b1;
                n_o_status = r_status;
                n_o_count  = r_count;
                if (r_status == orl_pkg::STAT_OK) begin
                    unique case (r_action)
                        orl_pkg::ACT_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(r_pos - 1'b1);
                            ram_wdata = r_new_rec;
                            n_count   = r_count + 1'b1;
                            n_o_count = r_count + 1'b1;
                        end
                        orl_pkg::ACT_DELETE: begin
                            n_count   = r_count - 1'b1;
                            n_o_count = r_count - 1'b1;
                        end
                        orl_pkg::ACT_EDIT: begin
                            if (!r_found) begin
                                n_o_status = orl_pkg::STAT_NOT_FOUND;
                            end
                        end
                        orl_pkg::ACT_READ: begin
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_pos       <= n_pos;
        r_key       <= n_key;
        r_new_rec   <= n_new_rec;
        r_status    <= n_status;
        r_idx       <= n_idx;
        r_pend_addr <= n_pend_addr;
        r_found     <= n_found;
        r_rd_rec    <= n_rd_rec;
        r_o_status  <= n_o_status;
        r_o_count   <= n_o_count;
    end

    assign w_rd_name = orl_pkg::NAME_ALL_W'(r_rd_rec[NAME_W-1:0]);

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_o_status;
    assign o_count_now    = orl_pkg::COUNT_W'(r_o_count);
    assign o_read_id      = r_rd_rec[REC_W-1:ID_LO];
    assign o_read_age     = r_rd_rec[AGE_LO+orl_pkg::BYTE_W-1:AGE_LO];
    assign o_read_group   = r_rd_rec[GRP_LO+orl_pkg::BYTE_W-1:GRP_LO];
    assign o_read_name_w0 = w_rd_name[orl_pkg::NAME_WORD_W-1:0];
    assign o_read_name_w1 = w_rd_name[2*orl_pkg::NAME_WORD_W-1:orl_pkg::NAME_WORD_W];
    assign o_read_name_w2 = w_rd_name[3*orl_pkg::NAME_WORD_W-1:2*orl_pkg::NAME_WORD_W];
    assign o_read_name_w3 = w_rd_name[4*orl_pkg::NAME_WORD_W-1:3*orl_pkg::NAME_WORD_W];

    // result strobe only right after the finishing state
    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished command");

    // table never grows past its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // RAM is written only while a command is in progress
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != S_IDLE))
        else $error("RAM write while idle");

    // no read data left in flight once the scan has ended
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("pending read outside the scan");

    // count changes only at the end of a command
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_count))
        else $error("entry count changed outside the finishing state");

endmodule

// ===== tb/tb_ordered_record_list_unit.sv =====
// Self-checking testbench for the ordered record list: directed and random commands.
`timescale 1ns / 1ps

module tb_ordered_record_list_unit;

    localparam int CAPACITY   = orl_pkg::CAPACITY_DEF;
    localparam int NAME_BYTES = orl_pkg::NAME_BYTES_DEF;
    localparam int RANDOM_WORDS = 650;

    // One command word and one result word, at the block's widths.
    typedef struct packed {
        orl_pkg::t_action action;
        logic [7:0]       position;
        logic [31:0]      match_id;
        logic [31:0]      new_id;
        logic [7:0]       age;
        logic [7:0]       group;
        logic [3:0][63:0] name;
    } t_command;

    typedef struct packed {
        orl_pkg::t_status status;
        logic [7:0]       count_now;
        logic [31:0]      id;
        logic [7:0]       age;
        logic [7:0]       group;
        logic [3:0][63:0] name;
    } t_result;

    // Record table mirror: applies each accepted command and queues the result it must give.
    class record_table_model;
        logic [31:0]      ids[CAPACITY];
        logic [7:0]       ages[CAPACITY];
        logic [7:0]       groups[CAPACITY];
        logic [3:0][63:0] names[CAPACITY];
        int               entries;
        t_result          pending[$];
        int               errors;

        function new();
            entries = 0;
            errors  = 0;
        endfunction

        function void copy_record(int dst, int src);
            ids[dst]    = ids[src];
            ages[dst]   = ages[src];
            groups[dst] = groups[src];
            names[dst]  = names[src];
        endfunction

        // name bytes at NAME_BYTES and above are kept as zero
        function void write_record(int idx, t_command c);
            int keep;
            ids[idx]    = c.new_id;
            ages[idx]   = c.age;
            groups[idx] = c.group;
            for (int w = 0; w < 4; w++) begin
                keep = NAME_BYTES - 8 * w;
                if (keep >= 8)
                    names[idx][w] = c.name[w];
                else if (keep <= 0)
                    names[idx][w] = '0;
                else
                    names[idx][w] = c.name[w] & ((64'd1 << (8 * keep)) - 64'd1);
            end
        endfunction

        function t_result apply_command(t_command c);
            t_result r;
            int      pos;
            bit      found;
            r = '0;
            r.status = orl_pkg::STAT_OK;
            pos = int'(c.position);
            case (c.action)
                orl_pkg::ACT_INSERT: begin
                    // position check takes priority over the full check
                    if (pos == 0 || pos > entries + 1) begin
                        r.status = orl_pkg::STAT_BAD_POS;
                    end else if (entries >= CAPACITY) begin
                        r.status = orl_pkg::STAT_FULL;
                    end else begin
                        for (int i = entries; i >= pos; i--)
                            copy_record(i, i - 1);
                        write_record(pos - 1, c);
                        entries++;
                    end
                end
                orl_pkg::ACT_DELETE: begin
                    if (pos == 0 || pos > entries) begin
                        r.status = orl_pkg::STAT_BAD_POS;
                    end else begin
                        for (int i = pos - 1; i + 1 < entries; i++)
                            copy_record(i, i + 1);
                        entries--;
                    end
                end
                orl_pkg::ACT_EDIT: begin
                    found = 1'b0;
                    for (int i = 0; i < entries; i++) begin
                        if (ids[i] == c.match_id) begin
                            write_record(i, c);
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        r.status = orl_pkg::STAT_NOT_FOUND;
                end
                default: begin
                    if (pos == 0 || pos > entries) begin
                        r.status = orl_pkg::STAT_BAD_POS;
                    end else begin
                        r.id    = ids[pos - 1];
                        r.age   = ages[pos - 1];
                        r.group = groups[pos - 1];
                        r.name  = names[pos - 1];
                    end
                end
            endcase
            r.count_now = entries[7:0];
            return r;
        endfunction

        function void note_command(t_command c);
            pending.push_back(apply_command(c));
        endfunction

        function void mismatch(string field, logic [63:0] want, logic [63:0] got);
            if (errors < 10)
                $display("%0t: mismatch on %s: expected %h, got %h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                if (errors < 10)
                    $display("%0t: result word with no command outstanding", $time);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status)
                mismatch("status", 64'(want.status), 64'(got.status));
            if (got.count_now != want.count_now)
                mismatch("count_now", 64'(want.count_now), 64'(got.count_now));
            if (got.id != want.id)
                mismatch("read_id", 64'(want.id), 64'(got.id));
            if (got.age != want.age)
                mismatch("read_age", 64'(want.age), 64'(got.age));
            if (got.group != want.group)
                mismatch("read_group", 64'(want.group), 64'(got.group));
            for (int w = 0; w < 4; w++)
                if (got.name[w] != want.name[w])
                    mismatch($sformatf("read_name_w%0d", w), want.name[w], got.name[w]);
        endfunction
    endclass

    // ---------------------------------------------------------------- DUT
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic [1:0]  i_action   = '0;
    logic [7:0]  i_position = '0;
    logic [31:0] i_match_id = '0;
    logic [31:0] i_new_id   = '0;
    logic [7:0]  i_new_age  = '0;
    logic [7:0]  i_new_group = '0;
    logic [63:0] i_new_name_w0 = '0;
    logic [63:0] i_new_name_w1 = '0;
    logic [63:0] i_new_name_w2 = '0;
    logic [63:0] i_new_name_w3 = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_count_now;
    logic [31:0] o_read_id;
    logic [7:0]  o_read_age;
    logic [7:0]  o_read_group;
    logic [63:0] o_read_name_w0;
    logic [63:0] o_read_name_w1;
    logic [63:0] o_read_name_w2;
    logic [63:0] o_read_name_w3;

    ordered_record_list_unit #(
        .CAPACITY   (CAPACITY),
        .NAME_BYTES (NAME_BYTES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_position     (i_position),
        .i_match_id     (i_match_id),
        .i_new_id       (i_new_id),
        .i_new_age      (i_new_age),
        .i_new_group    (i_new_group),
        .i_new_name_w0  (i_new_name_w0),
        .i_new_name_w1  (i_new_name_w1),
        .i_new_name_w2  (i_new_name_w2),
        .i_new_name_w3  (i_new_name_w3),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_count_now    (o_count_now),
        .o_read_id      (o_read_id),
        .o_read_age     (o_read_age),
        .o_read_group   (o_read_group),
        .o_read_name_w0 (o_read_name_w0),
        .o_read_name_w1 (o_read_name_w1),
        .o_read_name_w2 (o_read_name_w2),
        .o_read_name_w3 (o_read_name_w3)
    );

    always #5 i_clk = ~i_clk;

    record_table_model sb = new();
    int idle_pct = 27;

    // Results are sampled at the edge that ends the strobe cycle.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid) begin
            got.status    = orl_pkg::t_status'(o_status);
            got.count_now = o_count_now;
            got.id        = o_read_id;
            got.age       = o_read_age;
            got.group     = o_read_group;
            got.name      = {o_read_name_w3, o_read_name_w2, o_read_name_w1, o_read_name_w0};
            sb.check_result(got);
        end
    end

    // ---------------------------------------------------------------- driving
    // start is dropped on random cycles; the word goes in at the first edge
    // where start is high and busy is low.
    task automatic send_command(input t_command c);
        i_action      <= c.action;
        i_position    <= c.position;
        i_match_id    <= c.match_id;
        i_new_id      <= c.new_id;
        i_new_age     <= c.age;
        i_new_group   <= c.group;
        i_new_name_w0 <= c.name[0];
        i_new_name_w1 <= c.name[1];
        i_new_name_w2 <= c.name[2];
        i_new_name_w3 <= c.name[3];
        forever begin
            start <= ($urandom_range(0, 99) >= idle_pct);
            @(posedge i_clk);
            if (start && !busy)
                break;
        end
        sb.note_command(c);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_command make_cmd(orl_pkg::t_action act, logic [7:0] pos,
                                          logic [31:0] key, logic [31:0] id,
                                          logic [7:0] age, logic [7:0] group,
                                          logic [63:0] fill);
        t_command c;
        c.action   = act;
        c.position = pos;
        c.match_id = key;
        c.new_id   = id;
        c.age      = age;
        c.group    = group;
        c.name     = {4{fill}};
        return c;
    endfunction

    // small values repeat often so edits hit several records
    function automatic logic [31:0] random_id();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // mostly legal positions, with zero, one past the limit and wild values mixed in
    function automatic logic [7:0] pick_position(int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'd0;
        if (r < 14)
            return 8'(lim + 1);
        if (r < 18 || lim == 0)
            return 8'($urandom_range(0, 255));
        if (r < 24)
            return 8'd1;
        if (r < 30)
            return 8'(lim);
        return 8'($urandom_range(1, lim));
    endfunction

    // table fill is steered toward a target so full and empty are both reached
    function automatic t_command random_command(int target);
        t_command c;
        int       r;
        int       lim;
        c.new_id = random_id();
        c.age    = 8'($urandom_range(0, 255));
        c.group  = 8'($urandom_range(0, 255));
        for (int w = 0; w < 4; w++)
            c.name[w] = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (sb.entries < target)
            c.action = r < 85 ? orl_pkg::ACT_INSERT : r < 90 ? orl_pkg::ACT_DELETE :
                       r < 95 ? orl_pkg::ACT_EDIT : orl_pkg::ACT_READ;
        else
            c.action = r < 10 ? orl_pkg::ACT_INSERT : r < 55 ? orl_pkg::ACT_DELETE :
                       r < 75 ? orl_pkg::ACT_EDIT : orl_pkg::ACT_READ;
        lim = (c.action == orl_pkg::ACT_INSERT) ? sb.entries + 1 : sb.entries;
        c.position = pick_position(lim);
        if (sb.entries > 0 && $urandom_range(0, 99) < 70)
            c.match_id = sb.ids[$urandom_range(0, sb.entries - 1)];
        else
            c.match_id = random_id();
        return c;
    endfunction

    // ---------------------------------------------------------------- stimulus
    initial begin
        int target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: every position is bad, edit finds nothing
        send_command(make_cmd(orl_pkg::ACT_READ,   8'd1, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        send_command(make_cmd(orl_pkg::ACT_DELETE, 8'd1, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        send_command(make_cmd(orl_pkg::ACT_EDIT,   8'd0, 32'd0, 32'd1, 8'd1, 8'd1, 64'd1));
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd0, 32'd0, 32'd5, 8'd5, 8'd5, 64'd5));
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd2, 32'd0, 32'd5, 8'd5, 8'd5, 64'd5));
        // first insert, insert at front, append, insert in the middle
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd1, 32'd0, 32'h7FFF_FFFF, 8'hFF, 8'h00,
                              '1));
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd1, 32'd0, 32'h8000_0000, 8'h00, 8'hFF,
                              64'd0));
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd3, 32'd0, 32'hFFFF_FFFF, 8'h01, 8'h02,
                              64'hA5A5_A5A5_A5A5_A5A5));
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd2, 32'd0, 32'd0, 8'h80, 8'h7F,
                              64'h5A5A_5A5A_5A5A_5A5A));
        for (int p = 1; p <= 4; p++)
            send_command(make_cmd(orl_pkg::ACT_READ, 8'(p), 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        // positions past the end
        send_command(make_cmd(orl_pkg::ACT_READ,   8'd5,   32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        send_command(make_cmd(orl_pkg::ACT_READ,   8'd255, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd255, 32'd0, 32'd9, 8'd9, 8'd9, 64'd9));
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd6,   32'd0, 32'd9, 8'd9, 8'd9, 64'd9));
        // duplicate id, then an edit that rewrites both copies, then one that misses
        send_command(make_cmd(orl_pkg::ACT_INSERT, 8'd5, 32'd0, 32'd0, 8'd33, 8'd44,
                              64'h0123_4567));
        send_command(make_cmd(orl_pkg::ACT_EDIT, 8'd0, 32'd0, 32'h1234_5678, 8'd77, 8'd88,
                              64'hDEAD_BEEF_0BAD_F00D));
        send_command(make_cmd(orl_pkg::ACT_EDIT, 8'd0, 32'd0, 32'd1, 8'd1, 8'd1, 64'd1));
        send_command(make_cmd(orl_pkg::ACT_READ, 8'd5, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        // delete last, delete first, then bad positions
        send_command(make_cmd(orl_pkg::ACT_DELETE, 8'd5, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        send_command(make_cmd(orl_pkg::ACT_DELETE, 8'd1, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        send_command(make_cmd(orl_pkg::ACT_DELETE, 8'd0, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        send_command(make_cmd(orl_pkg::ACT_DELETE, 8'd4, 32'd0, 32'd0, 8'd0, 8'd0, 64'd0));
        wait_drained();

        // random part: sender idles 27%, then 50%, then not at all
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                wait_drained();
                idle_pct = 50;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                wait_drained();
                idle_pct = 0;
            end
            target = n < 200 ? CAPACITY : n < 330 ? 0 : n < 450 ? 64 : n < 600 ? CAPACITY : 20;
            send_command(random_command(target));
        end

        wait_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // time limit sized for about 700 words at the worst case per command plus sender gaps
    initial begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/orl_pkg.sv
rtl/orl_ram.sv
rtl/ordered_record_list_unit.sv
tb/tb_ordered_record_list_unit.sv
